@@ rtl/factorial_trailing_zeros_base_macros.svh @@
// Assertion macros for the factorial trailing zeros block.
// Included by the top level; depends on nothing else.
`ifndef FACTORIAL_TRAILING_ZEROS_BASE_MACROS_SVH
`define FACTORIAL_TRAILING_ZEROS_BASE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FTZ_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define FTZ_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/ftz_pkg.sv @@
// Shared constants, types and sequencer states for the factorial trailing zeros block.
// No dependencies.
package ftz_pkg;

  localparam int N_WIDTH     = 20;
  localparam int RADIX_WIDTH = 10;
  localparam int DIV_W       = (N_WIDTH > RADIX_WIDTH) ? N_WIDTH : RADIX_WIDTH;
  localparam int CNT_W       = $clog2(DIV_W + 1);
  localparam int CAND_W      = RADIX_WIDTH + 1;
  localparam int PW          = N_WIDTH + RADIX_WIDTH;
  localparam int MULT_W      = $clog2(RADIX_WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAND,
    S_RDIV,
    S_LEG,
    S_LDIV,
    S_SHARE,
    S_SDIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

@@ rtl/ftz_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
// Depends on ftz_pkg for widths and the request and response structs.
module ftz_div (
  input  logic              clk,
  input  logic              rst,
  input  ftz_pkg::div_req_t req,
  output ftz_pkg::div_rsp_t rsp
);

  logic [ftz_pkg::DIV_W:0]     rem;
  logic [ftz_pkg::DIV_W-1:0]   quo;
  logic [ftz_pkg::DIV_W-1:0]   dvs;
  logic [ftz_pkg::CNT_W-1:0]   cnt;
  logic                        busy;
  logic                        done;
  logic [ftz_pkg::DIV_W:0]     shifted;
  logic                        fits;

  assign shifted = {rem[ftz_pkg::DIV_W-1:0], quo[ftz_pkg::DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == ftz_pkg::CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
      cnt <= ftz_pkg::CNT_W'(ftz_pkg::DIV_W);
    end else if (busy) begin
      rem <= fits ? (shifted - {1'b0, dvs}) : shifted;
      quo <= {quo[ftz_pkg::DIV_W-2:0], fits};
      cnt <= cnt - ftz_pkg::CNT_W'(1);
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem[ftz_pkg::DIV_W-1:0];

endmodule

@@ rtl/factorial_trailing_zeros_base.sv @@
// Top level: trailing zero digits of n! in a given radix, by trial division and Legendre sums.
// Depends on ftz_pkg, ftz_div and factorial_trailing_zeros_base_macros.svh.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------
//   input   | in_valid, in_ready  | n [19:0], radix [9:0]
//   output  | out_valid, out_ready| zeros [19:0]
//
// One beat is worked at a time; in_ready is high only while the sequencer is idle.
// Each item runs the single divider once per candidate test, once per prime power in
// each Legendre sum and once per prime factor of the radix; a large prime radix such as
// 1021 tries the most candidates.
// The shared one-bit-per-cycle divider bounds the run time.
// Reset returns the sequencer to idle; the result beat holds until out_ready takes it.
`include "factorial_trailing_zeros_base_macros.svh"

module factorial_trailing_zeros_base (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ftz_pkg::N_WIDTH-1:0]     n,
  input  logic [ftz_pkg::RADIX_WIDTH-1:0] radix,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ftz_pkg::N_WIDTH-1:0]     zeros
);

  ftz_pkg::state_t state;
  ftz_pkg::state_t state_next;

  logic [ftz_pkg::N_WIDTH-1:0]     n_r;
  logic [ftz_pkg::RADIX_WIDTH-1:0] rest;
  logic [ftz_pkg::CAND_W-1:0]      cand;
  logic [ftz_pkg::MULT_W-1:0]      mult;
  logic [ftz_pkg::PW-1:0]          power;
  logic [ftz_pkg::N_WIDTH-1:0]     sum;
  logic [ftz_pkg::N_WIDTH-1:0]     best;
  logic                            found;

  ftz_pkg::div_req_t div_req;
  ftz_pkg::div_rsp_t div_rsp;

  logic cand_over;
  logic power_over;
  logic rem_zero;

  assign cand_over  = (mult == '0) && (cand > {1'b0, rest});
  assign power_over = power > ftz_pkg::PW'(n_r);
  assign rem_zero   = div_rsp.remainder == '0;

  ftz_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ftz_pkg::S_IDLE:  if (in_valid) state_next = ftz_pkg::S_CAND;
      ftz_pkg::S_CAND:  state_next = cand_over ? ftz_pkg::S_DONE : ftz_pkg::S_RDIV;
      ftz_pkg::S_RDIV: begin
        if (div_rsp.done) begin
          if (rem_zero) begin
            state_next = ftz_pkg::S_CAND;
          end else if (mult == '0) begin
            state_next = ftz_pkg::S_CAND;
          end else begin
            state_next = ftz_pkg::S_LEG;
          end
        end
      end
      ftz_pkg::S_LEG:   state_next = power_over ? ftz_pkg::S_SHARE : ftz_pkg::S_LDIV;
      ftz_pkg::S_LDIV:  if (div_rsp.done) state_next = ftz_pkg::S_LEG;
      ftz_pkg::S_SHARE: state_next = ftz_pkg::S_SDIV;
      ftz_pkg::S_SDIV:  if (div_rsp.done) state_next = ftz_pkg::S_CAND;
      ftz_pkg::S_DONE:  if (out_ready) state_next = ftz_pkg::S_IDLE;
      default:          state_next = ftz_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    out_valid        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = ftz_pkg::DIV_W'(rest);
    div_req.divisor  = ftz_pkg::DIV_W'(cand);
    unique case (state)
      ftz_pkg::S_IDLE:  in_ready = 1'b1;
      ftz_pkg::S_CAND:  div_req.start = !cand_over;
      ftz_pkg::S_LEG: begin
        div_req.start    = !power_over;
        div_req.dividend = ftz_pkg::DIV_W'(n_r);
        div_req.divisor  = ftz_pkg::DIV_W'(power);
      end
      ftz_pkg::S_SHARE: begin
        div_req.start    = 1'b1;
        div_req.dividend = ftz_pkg::DIV_W'(sum);
        div_req.divisor  = ftz_pkg::DIV_W'(mult);
      end
      ftz_pkg::S_DONE:  out_valid = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftz_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ftz_pkg::S_IDLE: begin
        if (in_valid) begin
          n_r   <= n;
          rest  <= radix;
          cand  <= ftz_pkg::CAND_W'(2);
          mult  <= '0;
          best  <= '1;
          found <= 1'b0;
        end
      end
      ftz_pkg::S_RDIV: begin
        if (div_rsp.done) begin
          if (rem_zero) begin
            mult <= mult + ftz_pkg::MULT_W'(1);
            rest <= ftz_pkg::RADIX_WIDTH'(div_rsp.quotient);
          end else if (mult == '0) begin
            cand <= cand + ftz_pkg::CAND_W'(1);
          end else begin
            power <= ftz_pkg::PW'(cand);
            sum   <= '0;
          end
        end
      end
      ftz_pkg::S_LDIV: begin
        if (div_rsp.done) begin
          sum   <= sum + ftz_pkg::N_WIDTH'(div_rsp.quotient);
          power <= ftz_pkg::PW'(power * ftz_pkg::PW'(cand));
        end
      end
      ftz_pkg::S_SDIV: begin
        if (div_rsp.done) begin
          if (ftz_pkg::N_WIDTH'(div_rsp.quotient) < best) begin
            best <= ftz_pkg::N_WIDTH'(div_rsp.quotient);
          end
          found <= 1'b1;
          cand  <= cand + ftz_pkg::CAND_W'(1);
          mult  <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign zeros = best;

  `FTZ_ASSERT_IMP(a_div_start_idle, clk, rst, div_req.start, !div_rsp.busy)
  `FTZ_ASSERT_NXT(a_accept_starts, clk, rst, in_valid && in_ready, state == ftz_pkg::S_CAND)
  `FTZ_ASSERT_IMP(a_zeros_bound, clk, rst, out_valid && found, zeros <= n_r)

endmodule
